/* rtl/lbsc_pkg.sv */
// ----------------------------------------------------------------------------
// lbsc_pkg: shared types and constants of the LRU block slot cache
// Field widths, command and register codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package lbsc_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 64;
  localparam int BYTES_W = 32;
  localparam int SLOT_W  = 6;
  localparam int OFF_W   = 38;
  localparam int CNT_W   = 32;
  localparam int CAP_W   = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0]   CAP_RST = CAP_W'(64);
  localparam logic [BYTES_W-1:0] BB_RST  = BYTES_W'(4096);

  // register select taken from paddr[2]
  localparam logic REG_CAP = 1'b0;
  localparam logic REG_BB  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_EVICT  = 2'd2,
    CMD_PUT    = 2'd3
  } cmd_t;

  // which cell an update moves to the front
  typedef enum logic [1:0] {
    K_HIT,
    K_LAST,
    K_FREE
  } kind_t;

  typedef struct packed {
    logic            cmp_en;
    logic [ID_W-1:0] cmp_id;
    logic            upd;
    kind_t           kind;
    logic            clr_last;
  } ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* rtl/lbsc_if.sv */
// ----------------------------------------------------------------------------
// lbsc channels: request and response interfaces
// Valid/ready channels that carry one request or one result per transfer.
// ----------------------------------------------------------------------------
interface lbsc_req_if;
  import lbsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ID_W-1:0]      blk_id;
  logic [BYTES_W-1:0]   byte_count;
  modport source (output valid, cmd, blk_id, byte_count, input ready);
  modport sink   (input valid, cmd, blk_id, byte_count, output ready);
endinterface

interface lbsc_rsp_if;
  import lbsc_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [OFF_W-1:0]   byte_offset;
  logic               evicted;
  logic [ID_W-1:0]    evicted_id;
  logic               size_error;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   miss_count;
  logic [CNT_W-1:0]   evict_count;
  modport source (output valid, hit, slot, byte_offset, evicted, evicted_id, size_error,
                  hit_count, miss_count, evict_count, input ready);
  modport sink   (input valid, hit, slot, byte_offset, evicted, evicted_id, size_error,
                  hit_count, miss_count, evict_count, output ready);
endinterface

/* rtl/lbsc_cell.sv */
// ----------------------------------------------------------------------------
// lbsc_cell: one recency position of the directory
// Holds one entry, compares it, and takes its left neighbor on a move.
// ----------------------------------------------------------------------------
module lbsc_cell #(
  parameter int SW = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lbsc_pkg::ctl_t          ctl,
  input  logic                    left_valid,
  input  logic [lbsc_pkg::ID_W-1:0] left_id,
  input  logic [SW-1:0]           left_slot,
  input  logic                    right_valid,
  input  logic                    tail_in,
  output logic                    tail_out,
  output logic                    valid,
  output logic [lbsc_pkg::ID_W-1:0] id,
  output logic [SW-1:0]           slot,
  output logic                    match,
  output logic                    is_last
);
  import lbsc_pkg::*;

  logic target;
  logic take;

  assign is_last = valid & ~right_valid;

  always_comb begin
    case (ctl.kind)
      K_HIT:   target = match;
      K_LAST:  target = is_last;
      K_FREE:  target = ~valid & left_valid;
      default: target = 1'b0;
    endcase
  end

  // a target here or further right pulls this cell one step back
  assign tail_out = tail_in | target;
  assign take     = ctl.upd & tail_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match <= valid & (id == ctl.cmp_id);
      end
      if (take) begin
        valid <= left_valid;
      end else if (ctl.clr_last && is_last) begin
        valid <= 1'b0;
      end
    end
    if (take) begin
      id   <= left_id;
      slot <= left_slot;
    end
  end

endmodule

/* rtl/lru_block_slot_cache_unit.sv */
// ----------------------------------------------------------------------------
// lru_block_slot_cache_unit: fully associative LRU block-to-slot directory
// Maps 64-bit block ids to buffer slots over a chain of recency cells.
// ----------------------------------------------------------------------------
// For each request, the transfer cycle compares the block id
// against every cell in parallel and registers the match bits, and the
// following cycle moves the chosen cell to the front of the chain (all cells
// in front of it step back by one), loads the result register and returns to
// idle. A new request is taken once the block is idle and the result register
// is empty or being drained. Cells are kept in recency order, most recent in
// cell 0, valid cells packed at the front; the least recently used entry is
// always the last valid cell. The byte offset is one slot-by-block-size
// multiply in the update cycle. Configuration writes are taken at any time
// but must only happen while the block is idle.
// ----------------------------------------------------------------------------
module lru_block_slot_cache_unit #(
  parameter int MAX_ENTRIES = lbsc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  lbsc_req_if.sink                    req,
  lbsc_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbsc_pkg::ADDR_W-1:0] paddr,
  input  logic [lbsc_pkg::DATA_W-1:0] pwdata,
  output logic [lbsc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import lbsc_pkg::*;

  localparam int SW   = $clog2(MAX_ENTRIES);
  localparam int FW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;
  localparam int PW   = SW + BYTES_W;

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t state;

  // configuration
  logic [CAP_W-1:0]   cap;
  logic [BYTES_W-1:0] bb;

  // request hold
  cmd_t               cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [BYTES_W-1:0] bytes_q;

  // directory side state
  logic [FW-1:0] fresh;
  logic [SW-1:0] spare;
  logic          spare_v;
  logic [CNT_W-1:0] hits, misses, evictions;

  // result register
  logic               out_v;
  logic               o_hit, o_ev, o_err;
  logic [SLOT_W-1:0]  o_slot;
  logic [OFF_W-1:0]   o_off;
  logic [ID_W-1:0]    o_ev_id;

  // chain wiring
  ctl_t ctl;
  logic [MAX_ENTRIES-1:0] v_vec, m_vec, last_vec;
  logic [MAX_ENTRIES:0]   tail;
  logic [ID_W-1:0]        c_id   [MAX_ENTRIES];
  logic [SW-1:0]          c_slot [MAX_ENTRIES];
  logic [ID_W-1:0]        l_id   [MAX_ENTRIES];
  logic [SW-1:0]          l_slot [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] l_v, r_v;

  logic acc;
  logic [SW-1:0] new_slot;

  // decisions of the update cycle
  logic          hit_any, any_valid, free_ok;
  logic [SW-1:0] hit_slot, last_slot, sel_slot;
  logic [ID_W-1:0] last_id;
  logic [CMPW-1:0] cap_eff;
  logic [PW-1:0]   prod;
  logic          d_hit, d_ev, d_err, d_spare_take, d_spare_put, d_fresh_take;
  logic          d_hitc, d_missc, d_evc;

  assign acc       = req.valid & req.ready;
  assign req.ready = (state == S_IDLE) & (~out_v | rsp.ready);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_BB) ? bb : DATA_W'(cap);

  // ---------------- cell chain ----------------
  assign tail[MAX_ENTRIES] = 1'b0;

  always_comb begin
    ctl.cmp_en   = acc;
    ctl.cmp_id   = req.blk_id;
    ctl.upd      = 1'b0;
    ctl.kind     = K_HIT;
    ctl.clr_last = 1'b0;
    if (state == S_UPD) begin
      case (cmd_q)
        CMD_LOOKUP: begin
          ctl.upd = hit_any;
        end
        CMD_EVICT: begin
          ctl.clr_last = ~free_ok & any_valid;
        end
        default: begin
          if (!(cmd_q == CMD_PUT && bytes_q > bb)) begin
            ctl.upd = 1'b1;
            if (hit_any) begin
              ctl.kind = K_HIT;
            end else if (!spare_v && !free_ok && any_valid) begin
              ctl.kind = K_LAST;
            end else begin
              ctl.kind = K_FREE;
            end
          end
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        // the head takes the new entry as its left neighbor
        assign l_v[g]    = 1'b1;
        assign l_id[g]   = id_q;
        assign l_slot[g] = new_slot;
      end else begin : g_body
        assign l_v[g]    = v_vec[g-1];
        assign l_id[g]   = c_id[g-1];
        assign l_slot[g] = c_slot[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_tail
        assign r_v[g] = 1'b0;
      end else begin : g_mid
        assign r_v[g] = v_vec[g+1];
      end
      lbsc_cell #(.SW(SW)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .left_valid  (l_v[g]),
        .left_id     (l_id[g]),
        .left_slot   (l_slot[g]),
        .right_valid (r_v[g]),
        .tail_in     (tail[g+1]),
        .tail_out    (tail[g]),
        .valid       (v_vec[g]),
        .id          (c_id[g]),
        .slot        (c_slot[g]),
        .match       (m_vec[g]),
        .is_last     (last_vec[g])
      );
    end
  endgenerate

  // ---------------- reductions over the chain ----------------
  always_comb begin
    hit_slot  = '0;
    last_slot = '0;
    last_id   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_slot  = hit_slot  | (c_slot[i] & {SW{m_vec[i]}});
      last_slot = last_slot | (c_slot[i] & {SW{last_vec[i]}});
      last_id   = last_id   | (c_id[i]   & {ID_W{last_vec[i]}});
    end
  end

  assign hit_any   = |m_vec;
  assign any_valid = v_vec[0];

  // clamp capacity to 1..MAX_ENTRIES
  always_comb begin
    if (cap == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap) > CMPW'(MAX_ENTRIES)) begin
      cap_eff = CMPW'(MAX_ENTRIES);
    end else begin
      cap_eff = CMPW'(cap);
    end
  end

  assign free_ok = spare_v | (CMPW'(fresh) < cap_eff);

  // ---------------- update-cycle decisions ----------------
  always_comb begin
    d_hit        = 1'b0;
    d_ev         = 1'b0;
    d_err        = 1'b0;
    d_spare_take = 1'b0;
    d_spare_put  = 1'b0;
    d_fresh_take = 1'b0;
    d_hitc       = 1'b0;
    d_missc      = 1'b0;
    d_evc        = 1'b0;
    new_slot     = '0;
    sel_slot     = '0;
    case (cmd_q)
      CMD_LOOKUP: begin
        if (hit_any) begin
          d_hit    = 1'b1;
          d_hitc   = 1'b1;
          new_slot = hit_slot;
          sel_slot = hit_slot;
        end else begin
          d_missc = 1'b1;
        end
      end
      CMD_EVICT: begin
        if (!free_ok && any_valid) begin
          d_spare_put = 1'b1;
          d_ev        = 1'b1;
          d_evc       = 1'b1;
        end
      end
      default: begin
        if (cmd_q == CMD_PUT && bytes_q > bb) begin
          d_err = 1'b1;
        end else if (hit_any) begin
          d_hit    = 1'b1;
          new_slot = hit_slot;
          sel_slot = hit_slot;
        end else if (spare_v) begin
          d_spare_take = 1'b1;
          new_slot     = spare;
          sel_slot     = spare;
        end else if (free_ok) begin
          d_fresh_take = 1'b1;
          new_slot     = SW'(fresh);
          sel_slot     = SW'(fresh);
        end else if (any_valid) begin
          d_ev     = 1'b1;
          d_evc    = 1'b1;
          new_slot = last_slot;
          sel_slot = last_slot;
        end
      end
    endcase
  end

  assign prod = PW'(sel_slot) * PW'(bb);

  // ---------------- control, state and result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RST;
      bb        <= BB_RST;
      fresh     <= '0;
      spare_v   <= 1'b0;
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
      out_v     <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_BB) begin
          bb <= pwdata;
        end else begin
          cap <= pwdata[CAP_W-1:0];
        end
      end
      if (rsp.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          state <= S_IDLE;
          out_v <= 1'b1;
          if (d_spare_take) begin
            spare_v <= 1'b0;
          end
          if (d_spare_put) begin
            spare_v <= 1'b1;
          end
          if (d_fresh_take) begin
            fresh <= fresh + FW'(1);
          end
          if (d_hitc) begin
            hits <= sat_inc(hits);
          end
          if (d_missc) begin
            misses <= sat_inc(misses);
          end
          if (d_evc) begin
            evictions <= sat_inc(evictions);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // payload, no reset needed
    if (acc) begin
      cmd_q   <= cmd_t'(req.cmd);
      id_q    <= req.blk_id;
      bytes_q <= req.byte_count;
    end
    if (state == S_UPD) begin
      if (d_spare_put) begin
        spare <= last_slot;
      end
      o_hit   <= d_hit;
      o_ev    <= d_ev;
      o_err   <= d_err;
      o_slot  <= SLOT_W'(sel_slot);
      o_off   <= OFF_W'(prod);
      o_ev_id <= d_ev ? last_id : '0;
    end
  end

  assign rsp.valid          = out_v;
  assign rsp.hit            = o_hit;
  assign rsp.slot           = o_slot;
  assign rsp.byte_offset    = o_off;
  assign rsp.evicted        = o_ev;
  assign rsp.evicted_id     = o_ev_id;
  assign rsp.size_error     = o_err;
  assign rsp.hit_count      = hits;
  assign rsp.miss_count     = misses;
  assign rsp.evict_count    = evictions;

  // ---------------- assertions ----------------
  // ids in the directory are unique, so at most one cell matches
  a_match_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $onehot0(m_vec))
    else $error("more than one cell matched");

  // valid cells stay packed at the front of the chain
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((v_vec >> 1) & ~v_vec) == '0)
    else $error("gap in valid cells");

  // fresh slot count never passes the directory depth
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(fresh) <= CMPW'(MAX_ENTRIES))
    else $error("fresh slot counter overran");

  // an accepted request gives a result after the update cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    acc |=> ##1 out_v)
    else $error("result not loaded");

endmodule

/* tb/tb_lru_block_slot_cache_unit.sv */
// ----------------------------------------------------------------------------
// tb_lru_block_slot_cache_unit: self-checking bench for the LRU slot directory
// Drives lookup, allocate, evict and put requests under several capacity and
// block size settings. Each transfer is checked field by field against a
// behavioral directory model kept in the bench, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_lru_block_slot_cache_unit;
  import lbsc_pkg::*;

  localparam int NSLOT    = 64;
  localparam int POOL_SZ  = 96;
  localparam int PHASE_N  = 360;
  localparam logic [ADDR_W-1:0] ADDR_CAP = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_BB  = 3'd4;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  byte_offset;
    logic              evicted;
    logic [ID_W-1:0]   evicted_id;
    logic              size_error;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  evict_count;
  } lookup_rsp_t;

  typedef struct {
    cmd_t               c;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] n;
    bit                 typed;
    lookup_rsp_t        r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  lbsc_req_if req_ch();
  lbsc_rsp_if rsp_ch();

  lru_block_slot_cache_unit u_top (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Directory model: entries are indexed by slot, recency list front = newest.
  logic [ID_W-1:0]    dir_ids [NSLOT];
  bit                 dir_valid [NSLOT];
  int                 recency [$];
  int                 fresh_slot;
  int                 spare_slot;
  bit                 spare_ok;
  logic [CNT_W-1:0]   n_hits, n_misses, n_evicts;
  logic [CAP_W-1:0]   cap_reg;
  logic [BYTES_W-1:0] bb_reg;

  lookup_rsp_t        pending_rsp [$];
  int                 errs = 0;
  int                 items_sent = 0;
  int                 tx_idle = 21, rx_idle = 82;
  bit                 hold_req = 0;
  int                 hold_cnt = 0;
  logic [ID_W-1:0]    id_pool [POOL_SZ];

  function automatic int cap_eff();
    if (cap_reg < 1) return 1;
    if (cap_reg > NSLOT) return NSLOT;
    return int'(cap_reg);
  endfunction

  function automatic int find_block(logic [ID_W-1:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (dir_valid[i] && dir_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  // Move an entry to most recent.
  function automatic void touch(int idx);
    foreach (recency[p])
      if (recency[p] == idx) begin
        recency.delete(p);
        break;
      end
    recency.insert(0, idx);
  endfunction

  // Drop the least recently used entry, return its slot.
  function automatic int drop_lru(output logic [ID_W-1:0] vid);
    int idx;
    idx = recency[recency.size() - 1];
    recency.delete(recency.size() - 1);
    vid = dir_ids[idx];
    dir_valid[idx] = 0;
    n_evicts = bump(n_evicts);
    return idx;
  endfunction

  function automatic lookup_rsp_t resolve(cmd_t c, logic [ID_W-1:0] id,
                                          logic [BYTES_W-1:0] n);
    lookup_rsp_t r;
    int f;
    int s;
    logic [69:0] prod;
    r = '{default: '0};
    s = 0;
    f = find_block(id);
    case (c)
      CMD_LOOKUP: begin
        if (f >= 0) begin
          n_hits = bump(n_hits);
          r.hit = 1;
          touch(f);
          s = f;
        end else begin
          n_misses = bump(n_misses);
        end
      end
      CMD_EVICT: begin
        if (!(spare_ok || fresh_slot < cap_eff()) && recency.size() > 0) begin
          spare_slot = drop_lru(r.evicted_id);
          spare_ok = 1;
          r.evicted = 1;
        end
      end
      default: begin
        if (c == CMD_PUT && n > bb_reg) begin
          r.size_error = 1;
        end else if (f >= 0) begin
          r.hit = 1;
          touch(f);
          s = f;
        end else begin
          if (spare_ok) begin
            s = spare_slot;
            spare_ok = 0;
          end else if (fresh_slot < cap_eff()) begin
            s = fresh_slot;
            fresh_slot++;
          end else if (recency.size() > 0) begin
            s = drop_lru(r.evicted_id);
            r.evicted = 1;
          end else begin
            s = 0;
          end
          dir_ids[s] = id;
          dir_valid[s] = 1;
          recency.insert(0, s);
        end
      end
    endcase
    prod = 70'(s) * 70'(bb_reg);
    r.slot = SLOT_W'(s);
    r.byte_offset = prod[OFF_W-1:0];
    r.hit_count = n_hits;
    r.miss_count = n_misses;
    r.evict_count = n_evicts;
    return r;
  endfunction

  // Directed opening: default capacity 64 and block size 4096 after reset.
  dir_row_t opening [] = '{
    '{CMD_LOOKUP, 64'h0, 32'h0, 1, '{0, 0, 0, 0, 0, 0, 0, 1, 0}},
    '{CMD_ALLOC,  64'h0, 32'h0, 1, '{0, 0, 0, 0, 0, 0, 0, 1, 0}},
    '{CMD_ALLOC,  '1,    32'h0, 1, '{0, 1, 4096, 0, 0, 0, 0, 1, 0}},
    '{CMD_PUT,    64'h5, 32'd4097, 1, '{0, 0, 0, 0, 0, 1, 0, 1, 0}},
    '{CMD_PUT,    64'h5, 32'd4096, 1, '{0, 2, 8192, 0, 0, 0, 0, 1, 0}},
    '{CMD_PUT,    64'h6, '1,       1, '{0, 0, 0, 0, 0, 1, 0, 1, 0}},
    '{CMD_LOOKUP, '1,    '1,       1, '{1, 1, 4096, 0, 0, 0, 1, 1, 0}},
    '{CMD_EVICT,  64'h0, 32'h0,    1, '{0, 0, 0, 0, 0, 0, 1, 1, 0}},
    '{CMD_ALLOC,  64'h0, '1,       1, '{1, 0, 0, 0, 0, 0, 1, 1, 0}},
    '{CMD_PUT,    64'h5, 32'h0,    1, '{1, 2, 8192, 0, 0, 0, 1, 1, 0}},
    '{CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'h0, 1, '{0, 0, 0, 0, 0, 0, 1, 2, 0}},
    '{CMD_ALLOC,  64'h8000_0000_0000_0000, 32'h0, 0, '{default: '0}},
    '{CMD_ALLOC,  64'h5555_5555_5555_5555, 32'h0, 0, '{default: '0}},
    '{CMD_PUT,    64'hAAAA_AAAA_AAAA_AAAA, 32'h1, 0, '{default: '0}},
    '{CMD_LOOKUP, 64'h5555_5555_5555_5555, 32'h0, 0, '{default: '0}},
    '{CMD_EVICT,  '1,    '1,       0, '{default: '0}}
  };

  // Hold the request valid until the transfer, then log the expected result.
  task automatic send_req(cmd_t c, logic [ID_W-1:0] id, logic [BYTES_W-1:0] n,
                          bit typed, lookup_rsp_t typed_rsp);
    lookup_rsp_t r;
    while ($urandom_range(99) < tx_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.cmd = c;
    req_ch.blk_id = id;
    req_ch.byte_count = n;
    do @(posedge clk); while (!req_ch.ready);
    r = resolve(c, id, n);
    pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : r);
    items_sent++;
    if (items_sent == 600) begin
      tx_idle = 82;
      rx_idle = 21;
    end else if (items_sent == 1200) begin
      tx_idle = 0;
      rx_idle = 0;
    end
    @(negedge clk);
  endtask

  // Drain outstanding results before touching the registers.
  task automatic settle();
    req_ch.valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = a;
    pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (a == ADDR_CAP) cap_reg = d[CAP_W-1:0];
    else bb_reg = d[BYTES_W-1:0];
  endtask

  task automatic random_phase(int count);
    int pool_n;
    int sel;
    cmd_t c;
    logic [ID_W-1:0] id;
    logic [BYTES_W-1:0] n;
    pool_n = cap_eff() + cap_eff() / 2 + 1;
    if (pool_n > POOL_SZ) pool_n = POOL_SZ;
    for (int k = 0; k < count; k++) begin
      c = cmd_t'($urandom_range(3));
      if ($urandom_range(99) < 80) id = id_pool[$urandom_range(pool_n - 1)];
      else id = {$urandom, $urandom};
      sel = $urandom_range(3);
      if (sel < 2) n = $urandom_range(bb_reg, 0);
      else if (sel == 2) n = $urandom;
      else n = bb_reg + BYTES_W'($urandom_range(1));
      // Stall the result side for a long stretch mid-phase to back up the input.
      if (k == count / 2) hold_req = 1;
      send_req(c, id, n, 0, '{default: '0});
    end
  endtask

  // Result side: random ready, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 0;
      hold_cnt <= 80;
      rsp_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic cmp_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %h, got %h", name, e, a);
      errs++;
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    lookup_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result transfer with no request outstanding");
        errs++;
      end else begin
        e = pending_rsp.pop_front();
        cmp_field("hit", e.hit, rsp_ch.hit);
        cmp_field("slot", e.slot, rsp_ch.slot);
        cmp_field("byte_offset", e.byte_offset, rsp_ch.byte_offset);
        cmp_field("evicted", e.evicted, rsp_ch.evicted);
        cmp_field("evicted_id", e.evicted_id, rsp_ch.evicted_id);
        cmp_field("size_error", e.size_error, rsp_ch.size_error);
        cmp_field("hit_count", e.hit_count, rsp_ch.hit_count);
        cmp_field("miss_count", e.miss_count, rsp_ch.miss_count);
        cmp_field("evict_count", e.evict_count, rsp_ch.evict_count);
      end
    end
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_LOOKUP;
    req_ch.blk_id = '0;
    req_ch.byte_count = '0;
    rsp_ch.ready = 1'b0;
    foreach (dir_valid[i]) dir_valid[i] = 0;
    fresh_slot = 0;
    spare_slot = 0;
    spare_ok = 0;
    n_hits = '0;
    n_misses = '0;
    n_evicts = '0;
    cap_reg = CAP_RST;
    bb_reg = BB_RST;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SZ; i++) id_pool[i] = {$urandom, $urandom};

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (opening[i])
      send_req(opening[i].c, opening[i].id, opening[i].n, opening[i].typed, opening[i].r);
    random_phase(PHASE_N - opening.size());

    // Small capacity, unit blocks: heavy eviction traffic.
    settle();
    reg_write(ADDR_CAP, 32'd4);
    reg_write(ADDR_BB, 32'd1);
    random_phase(PHASE_N);

    // Zero capacity acts as one; widest block size gives the largest offsets.
    settle();
    reg_write(ADDR_CAP, 32'd0);
    reg_write(ADDR_BB, 32'hFFFF_FFFF);
    random_phase(PHASE_N);

    // Oversized capacity clamps to the full store; zero block size.
    settle();
    reg_write(ADDR_CAP, 32'd127);
    reg_write(ADDR_BB, 32'd0);
    random_phase(PHASE_N);

    // Shrink capacity under live entries.
    settle();
    reg_write(ADDR_CAP, 32'd3);
    reg_write(ADDR_BB, 32'h0001_2345);
    random_phase(PHASE_N);

    settle();
    repeat (20) @(negedge clk);
    if (errs == 0 && pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lbsc_pkg.sv
rtl/lbsc_if.sv
rtl/lbsc_cell.sv
rtl/lru_block_slot_cache_unit.sv
tb/tb_lru_block_slot_cache_unit.sv
